[rtl/swdb_pkg.sv]
// Package for the switch debounce and long-press block.
// Holds the switch count, field widths, stream widths and the lane result type.
// It depends on nothing else.
`default_nettype none

package swdb_pkg;

    // Number of switches, one lane each (1 to 7).
    localparam int SWITCHES = 5;

    // Width of a sample window and of a held-tick counter.
    localparam int WIN_W = 8;
    localparam int CNT_W = 8;

    // Width of an event code and of the long-press limit register.
    localparam int EV_W    = 4;
    localparam int LIMIT_W = 8;

    // Event code meaning no event.
    localparam logic [EV_W-1:0] EV_NONE = '0;

    // Highest event code that can be raised.
    localparam int EV_MAX = 2 * SWITCHES;

    // Stream data widths, rounded up to whole bytes.
    localparam int IN_BITS     = SWITCHES + 1;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = EV_W + 2 * SWITCHES;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Configuration port.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_LONG_PRESS_TICKS = 1'b0;

    // What one lane reports after its update.
    typedef struct packed {
        logic pressed;
        logic long_f;
        logic short_ev;
        logic long_ev;
    } lane_result_t;

endpackage

`default_nettype wire

[rtl/swdb_lane.sv]
// One switch lane: sample window, held-tick counter and press flags.
// Depends on swdb_pkg.
`default_nettype none

module swdb_lane (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          en,
    input  wire                          level,
    input  wire [swdb_pkg::LIMIT_W-1:0]  limit,
    output swdb_pkg::lane_result_t       res
);

    logic [swdb_pkg::WIN_W-1:0] win_reg;
    logic [swdb_pkg::WIN_W-1:0] win_next;
    logic [swdb_pkg::CNT_W-1:0] hold_reg;
    logic [swdb_pkg::CNT_W-1:0] hold_next;
    logic                       pressed_reg;
    logic                       pressed_next;
    logic                       long_reg;
    logic                       long_next;
    logic                       short_ev;
    logic                       long_ev;

    always_comb
    begin
        win_next     = {win_reg[swdb_pkg::WIN_W-2:0], level};
        hold_next    = hold_reg;
        pressed_next = pressed_reg;
        long_next    = long_reg;
        short_ev     = 1'b0;
        long_ev      = 1'b0;

        if (win_next == '0)
        begin
            pressed_next = 1'b1;
            if (!long_reg)
            begin
                hold_next = hold_reg + 1'b1;
            end
        end
        else if (pressed_reg)
        begin
            // Any high sample ends the press; it is short unless already long.
            short_ev     = !long_reg;
            pressed_next = 1'b0;
            long_next    = 1'b0;
            hold_next    = '0;
        end

        if (swdb_pkg::CNT_W'(hold_next) > swdb_pkg::CNT_W'(limit))
        begin
            long_next = 1'b1;
            hold_next = '0;
            long_ev   = 1'b1;
        end
    end

    assign res.pressed  = pressed_next;
    assign res.long_f   = long_next;
    assign res.short_ev = short_ev;
    assign res.long_ev  = long_ev;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg     <= '0;
            hold_reg    <= '0;
            pressed_reg <= 1'b0;
            long_reg    <= 1'b0;
        end
        else if (en)
        begin
            win_reg     <= win_next;
            hold_reg    <= hold_next;
            pressed_reg <= pressed_next;
            long_reg    <= long_next;
        end
    end

endmodule

`default_nettype wire

[rtl/swdb_merge.sv]
// Merging stage: picks the winning event over all lanes and keeps the
// pending-event register. Depends on swdb_pkg.
`default_nettype none

module swdb_merge (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   en,
    input  wire                                   clear_event,
    input  swdb_pkg::lane_result_t                lanes [swdb_pkg::SWITCHES],
    output logic [swdb_pkg::EV_W-1:0]             event_next,
    output logic [swdb_pkg::SWITCHES-1:0]         pressed_flags,
    output logic [swdb_pkg::SWITCHES-1:0]         long_flags
);

    logic [swdb_pkg::EV_W-1:0] event_reg;
    logic [swdb_pkg::EV_W-1:0] winner;
    logic [swdb_pkg::EV_W-1:0] base;

    // Later (higher-numbered) lanes override earlier ones.
    always_comb
    begin
        winner = swdb_pkg::EV_NONE;
        for (int i = 0; i < swdb_pkg::SWITCHES; i++)
        begin
            if (lanes[i].short_ev)
            begin
                winner = swdb_pkg::EV_W'(i + 1);
            end
            if (lanes[i].long_ev)
            begin
                winner = swdb_pkg::EV_W'(swdb_pkg::SWITCHES + 1 + i);
            end
            pressed_flags[i] = lanes[i].pressed;
            long_flags[i]    = lanes[i].long_f;
        end
    end

    // The clear takes effect before the latch in the same tick.
    assign base       = clear_event ? swdb_pkg::EV_NONE : event_reg;
    assign event_next = (base == swdb_pkg::EV_NONE) ? winner : base;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            event_reg <= swdb_pkg::EV_NONE;
        end
        else if (en)
        begin
            event_reg <= event_next;
        end
    end

endmodule

`default_nettype wire

[rtl/switch_debounce_long_press_top.sv]
// Top level of the switch debounce and long-press detector: stream ports,
// configuration port and output register. Depends on swdb_pkg, swdb_lane, swdb_merge.
//
// Each input transaction is one tick carrying the raw, active-low levels of all
// switches plus a clear request for the pending event. Every switch has a lane of
// its own that shifts its level into an eight-sample window; an all-zero window
// means the switch is pressed, and each such tick counts towards the long-press
// limit held in the long_press_ticks register (byte address 0, reset value 50).
// Exceeding the limit raises a long event once; a release before that raises a
// short event. Where several switches raise events in one tick, the highest-numbered
// switch wins, and the pending event only takes a new code while it is empty or
// being cleared in that tick. All lanes update in parallel and the result lands in
// an output register in the cycle after acceptance. A new transaction is taken
// whenever that register is empty or is being drained in the same cycle, so with
// m_tready held high the block accepts one tick every clock cycle. The limit register
// must only be written while no tick is in flight.
`default_nettype none

module switch_debounce_long_press_top (
    input  wire                                 clk,
    input  wire                                 rst_n,
    // Input ticks. s_tdata from bit 0: switch_levels[4:0], clear_event, zero padding.
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire [swdb_pkg::IN_TDATA_W-1:0]      s_tdata,
    // Results. m_tdata from bit 0: pending_event[3:0], pressed_flags[4:0],
    // long_flags[4:0], zero padding.
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    output logic [swdb_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // Configuration port.
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire [swdb_pkg::APB_AW-1:0]          paddr,
    input  wire [swdb_pkg::APB_DW-1:0]          pwdata,
    output logic [swdb_pkg::APB_DW-1:0]         prdata,
    output logic                                pready
);

    logic [swdb_pkg::LIMIT_W-1:0]       limit_reg;
    logic                               out_valid_reg;
    logic [swdb_pkg::OUT_TDATA_W-1:0]   out_data_reg;
    logic                               accept;
    logic [swdb_pkg::SWITCHES-1:0]      levels;
    logic                               clear_event;
    swdb_pkg::lane_result_t             lane_res [swdb_pkg::SWITCHES];
    logic [swdb_pkg::EV_W-1:0]          event_next;
    logic [swdb_pkg::SWITCHES-1:0]      pressed_flags;
    logic [swdb_pkg::SWITCHES-1:0]      long_flags;
    logic                               reg_sel;

    // Configuration register: only the word at address 0 is implemented.
    assign pready  = 1'b1;
    assign reg_sel = (paddr[swdb_pkg::APB_AW-1] == swdb_pkg::REG_LONG_PRESS_TICKS);
    assign prdata  = reg_sel ? swdb_pkg::APB_DW'(limit_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= swdb_pkg::LIMIT_W'(50);
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            limit_reg <= pwdata[swdb_pkg::LIMIT_W-1:0];
        end
    end

    // A tick is taken whenever the output register is free or draining.
    assign s_tready    = !out_valid_reg || m_tready;
    assign accept      = s_tvalid && s_tready;
    assign levels      = s_tdata[swdb_pkg::SWITCHES-1:0];
    assign clear_event = s_tdata[swdb_pkg::SWITCHES];

    for (genvar g = 0; g < swdb_pkg::SWITCHES; g++)
    begin : g_lane
        swdb_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (accept),
            .level (levels[g]),
            .limit (limit_reg),
            .res   (lane_res[g])
        );
    end

    swdb_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (accept),
        .clear_event   (clear_event),
        .lanes         (lane_res),
        .event_next    (event_next),
        .pressed_flags (pressed_flags),
        .long_flags    (long_flags)
    );

    // Output register holding one finished result until it is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= swdb_pkg::OUT_TDATA_W'({long_flags, pressed_flags, event_next});
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

[rtl/swdb_checker.sv]
// Port-level checker for the switch debounce block, bound to the top level.
// Depends on swdb_pkg and switch_debounce_long_press_top.
`default_nettype none

module swdb_checker (
    input wire                                 clk,
    input wire                                 rst_n,
    input wire                                 s_tvalid,
    input wire                                 s_tready,
    input wire                                 m_tvalid,
    input wire                                 m_tready,
    input wire [swdb_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    localparam int PF_LO = swdb_pkg::EV_W;
    localparam int LF_LO = swdb_pkg::EV_W + swdb_pkg::SWITCHES;

    // A stalled result stays valid and unchanged.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Every accepted tick yields a result in the next cycle.
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted tick gave no result");

    // The event code stays within the defined codes.
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[swdb_pkg::EV_W-1:0] <= swdb_pkg::EV_W'(swdb_pkg::EV_MAX))
        else $error("event code out of range");

    // A switch can only be long-pressed while it is pressed.
    a_long: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[LF_LO +: swdb_pkg::SWITCHES]
                      & ~m_tdata[PF_LO +: swdb_pkg::SWITCHES]) == '0)
        else $error("long flag without pressed flag");

endmodule

bind switch_debounce_long_press_top swdb_checker u_swdb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
